FILE: src/wwtr_pkg.sv
// Shared types and constants for the whole-word token replacer.
// Used by every module in src; depends on nothing else.
package wwtr_pkg;

    // Token delimiter.
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TARGET_WORD        = 2'd0,
        CFG_TARGET_LENGTH      = 2'd1,
        CFG_REPLACEMENT_WORD   = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // One input item.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        text_done;
        logic [31:0] replacements_so_far;
    } t_out_item;

    // Burst of results caused by one input item: a leading run of bytes
    // taken from a word, then an optional trailing byte.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  base_len;
        logic [7:0]  tail;
        logic [3:0]  total;
        logic        end_of_text;
        logic [31:0] count;
    } t_run;

    // Force a length into the range 1..max_len.
    function automatic logic [3:0] clamp_len(input logic [3:0] len,
                                             input logic [3:0] max_len);
        logic [3:0] res;
        if (len == 4'd0) begin
            res = 4'd1;
        end else if (len > max_len) begin
            res = max_len;
        end else begin
            res = len;
        end
        return res;
    endfunction

endpackage

FILE: src/wwtr_token_ctl.sv
// Token match tracking and result burst builder for one text byte.
// Depends on wwtr_pkg for the item, burst and delimiter definitions.
module wwtr_token_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  wwtr_pkg::t_in_item i_item,
    input  logic [63:0]        i_target_word,
    input  logic [3:0]         i_target_len,
    input  logic [63:0]        i_repl_word,
    input  logic [3:0]         i_repl_len,
    output wwtr_pkg::t_run     o_run,
    output logic               o_has_run
);
    import wwtr_pkg::*;

    logic [3:0]  r_mpl;
    logic        r_pt;
    logic [31:0] r_count;
    logic [3:0]  n_mpl;
    logic        n_pt;
    logic [31:0] n_count;

    logic        is_space;
    logic        byte_hit;
    logic [3:0]  mpl_inc;
    logic        use_repl;
    logic        bump;
    logic        has_tail;
    logic [3:0]  base_len;

    assign is_space = (i_item.text_byte == SPACE_BYTE);
    assign mpl_inc  = r_mpl + 4'd1;
    assign byte_hit = (r_mpl < i_target_len) &&
                      (i_item.text_byte == i_target_word[{r_mpl[2:0], 3'b000} +: 8]);

    // Decide the next match state and the shape of the result burst.
    always_comb begin
        n_mpl    = r_mpl;
        n_pt     = r_pt;
        use_repl = 1'b0;
        bump     = 1'b0;
        has_tail = 1'b0;
        base_len = 4'd0;
        if (is_space) begin
            // A space closes the token: replacement or held prefix, then the space.
            has_tail = 1'b1;
            if (!r_pt && r_mpl == i_target_len) begin
                use_repl = 1'b1;
                base_len = i_repl_len;
                bump     = 1'b1;
            end else if (!r_pt) begin
                base_len = r_mpl;
            end
            n_mpl = 4'd0;
            n_pt  = 1'b0;
        end else if (r_pt) begin
            has_tail = 1'b1;
            if (i_item.end_of_text) begin
                n_pt = 1'b0;
            end
        end else if (byte_hit) begin
            // Still a prefix of the target: hold unless the text ends here.
            n_mpl = mpl_inc;
            if (i_item.end_of_text) begin
                if (mpl_inc == i_target_len) begin
                    use_repl = 1'b1;
                    base_len = i_repl_len;
                    bump     = 1'b1;
                end else begin
                    base_len = mpl_inc;
                end
                n_mpl = 4'd0;
            end
        end else begin
            // Mismatch: release the held prefix and this byte.
            base_len = r_mpl;
            has_tail = 1'b1;
            n_mpl    = 4'd0;
            n_pt     = !i_item.end_of_text;
        end
    end

    // Saturating replacement count.
    always_comb begin
        n_count = r_count;
        if (bump && r_count != 32'hFFFF_FFFF) begin
            n_count = r_count + 32'd1;
        end
    end

    always_comb begin
        o_run.word        = use_repl ? i_repl_word : i_target_word;
        o_run.base_len    = base_len;
        o_run.tail        = i_item.text_byte;
        o_run.total       = base_len + {3'b000, has_tail};
        o_run.end_of_text = i_item.end_of_text;
        o_run.count       = n_count;
    end

    assign o_has_run = (o_run.total != 4'd0);

    // Match state, updated once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpl   <= 4'd0;
            r_pt    <= 1'b0;
            r_count <= 32'd0;
        end else if (i_take) begin
            r_mpl   <= n_mpl;
            r_pt    <= n_pt;
            r_count <= n_count;
        end
    end

endmodule

FILE: src/wwtr_run_buf.sv
// Result register that drains one burst one byte per transfer.
// Depends on wwtr_pkg for the burst and result item types.
module wwtr_run_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  wwtr_pkg::t_run      i_run,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wwtr_pkg::t_out_item o_out_item
);
    import wwtr_pkg::*;

    logic       r_valid;
    logic [3:0] r_idx;
    t_run       r_run;
    logic [3:0] idx_inc;
    logic       last;
    logic       beat;

    assign idx_inc     = r_idx + 4'd1;
    assign last        = (idx_inc == r_run.total);
    assign beat        = r_valid && i_out_ready;
    assign o_free      = !r_valid || (beat && last);
    assign o_out_valid = r_valid;

    // Current result: word bytes first, then the trailing byte.
    always_comb begin
        o_out_item.out_byte = (r_idx < r_run.base_len) ?
                              r_run.word[{r_idx[2:0], 3'b000} +: 8] : r_run.tail;
        o_out_item.last_of_run         = last;
        o_out_item.text_done           = last && r_run.end_of_text;
        o_out_item.replacements_so_far = r_run.count;
    end

    // Burst control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 4'd0;
        end else if (beat && last) begin
            r_valid <= 1'b0;
        end else if (beat) begin
            r_idx <= idx_inc;
        end
    end

    // Burst payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
    end

endmodule

FILE: src/whole_word_token_replacer.sv
// Top level of the whole-word token replacer.
// Depends on wwtr_pkg, wwtr_token_ctl and wwtr_run_buf.
//
// Usage: text bytes enter on the input channel (valid/ready), one byte per
// transfer, with end_of_text set on the final byte. Rewritten bytes leave on
// the output channel, one byte per transfer. A token equal to the target word
// comes out as the replacement word; other bytes come out unchanged.
// Configuration is written through the plain write port while the block is
// idle; lengths outside 1..MAX_TOKEN_BYTES are clamped.
// An accepted byte waits in the input register until it is processed; a byte
// that yields results is then loaded into the result register, which offers
// its first result.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver is ready. A byte that releases a burst of results (up to
// MAX_TOKEN_BYTES + 1) occupies the result register until its last result is
// taken; bytes held as part of a partial match produce no result and pass even while the result register is busy.
// Receiver stall: the result register holds its byte, and the input register
// keeps taking bytes until it holds one that yields results; then ready drops.
// Reset: words return to 0, lengths to 1, match state and count to zero.
module whole_word_token_replacer #(
    parameter int MAX_TOKEN_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wwtr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wwtr_pkg::t_out_item o_out_item
);
    import wwtr_pkg::*;

    localparam logic [3:0] MaxLen = 4'(MAX_TOKEN_BYTES);

    logic [63:0] r_target_word;
    logic [3:0]  r_target_len;
    logic [63:0] r_repl_word;
    logic [3:0]  r_repl_len;
    logic        r_in_valid;
    t_in_item    r_in_item;

    logic        take;
    logic        has_run;
    logic        buf_free;
    t_run        run;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_word <= 64'd0;
            r_target_len  <= 4'd1;
            r_repl_word   <= 64'd0;
            r_repl_len    <= 4'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_WORD:        r_target_word <= i_cfg_data;
                CFG_TARGET_LENGTH:      r_target_len  <= i_cfg_data[3:0];
                CFG_REPLACEMENT_WORD:   r_repl_word   <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_repl_len    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input register: frees when its byte is processed.
    assign take       = r_in_valid && (buf_free || !has_run);
    assign o_in_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    wwtr_token_ctl u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_item        (r_in_item),
        .i_target_word (r_target_word),
        .i_target_len  (clamp_len(r_target_len, MaxLen)),
        .i_repl_word   (r_repl_word),
        .i_repl_len    (clamp_len(r_repl_len, MaxLen)),
        .o_run         (run),
        .o_has_run     (has_run)
    );

    wwtr_run_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take && has_run),
        .i_run       (run),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    // A burst never overwrites one that is still draining.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && has_run) |-> buf_free)
        else $error("burst loaded while result register busy");

    // A burst that is not finished keeps offering results.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_item.last_of_run) |=> o_out_valid)
        else $error("burst ended before its last result");

    // The replacement count seen on the output never goes down.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=>
        (!o_out_valid || o_out_item.replacements_so_far >=
         $past(o_out_item.replacements_so_far)))
        else $error("replacement count decreased");
`endif

endmodule
